>>> src/assert_macros.svh
// Assertion macros used by the deque core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk while reset is released.
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen while reset is released.
`define DEQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/deq_pkg.sv
// Package with the item types, operation codes and status codes of the deque.
`timescale 1ns / 1ps
package deq_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [DataW-1:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [1:0]              status;
  } deq_out_t;

  // Commands broadcast to every cell; at most one is set in a cycle.
  typedef struct packed {
    logic                    push_front;
    logic                    push_back;
    logic                    pop_front;
    logic                    pop_back;
    logic signed [DataW-1:0] push_value;
  } deq_ctrl_t;

endpackage

>>> src/double_ended_queue_core.sv
// Top level of the bounded double-ended queue built from a chain of cells.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// The in_ channel carries one request item (op and push_value) with a
// valid/ready handshake; the out_ channel returns exactly one result item
// (read_value and status) per request, in request order.
// Words are held in a row of DEPTH cells with the front word in cell 0.
// A push or pop at the front shifts every cell by one place at once; a
// push or pop at the back changes only the cell at the edge of the
// occupied run. The back word is picked out by each cell's own last flag.
// The result of an accepted item is held in the output register and shown
// in the cycle after it is accepted. While out_ready is high one item is
// taken per cycle, set by the single update of the cell row and output register.
// The output register decouples the channels: while out_ready is low a
// result waits there, and in_ready falls until it is taken.
// Reset (rst_n low, synchronous) empties the deque and drops any pending
// result. Errors (underflow on empty, overflow on full) leave the contents
// as they were and return read_value zero.
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::deq_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::deq_out_t  out_data
);

  logic                             accept;
  logic                             full;
  logic                             empty;
  logic [DEPTH-1:0]                 occ_vec;
  logic [DEPTH-1:0]                 last_vec;
  logic signed [deq_pkg::DataW-1:0] cell_data [DEPTH];
  logic signed [deq_pkg::DataW-1:0] back_value;
  deq_pkg::deq_ctrl_t               ctrl;
  deq_pkg::deq_out_t                result;
  deq_pkg::deq_out_t                out_r;
  logic                             out_valid_r;
  logic                             out_valid_nxt;

  // A new item is taken whenever the output register is empty or is being
  // emptied in this same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // The occupied cells always form a run starting at cell 0.
  assign empty = !occ_vec[0];
  assign full  = occ_vec[DEPTH-1];

  // Decode the request into cell commands, and form its result.
  always_comb begin
    ctrl            = '0;
    ctrl.push_value = in_data.push_value;
    result          = '0;
    result.status   = deq_pkg::ST_OK;
    case (in_data.op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          result.status = deq_pkg::ST_OVER;
        end else begin
          ctrl.push_front = accept;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          result.status = deq_pkg::ST_OVER;
        end else begin
          ctrl.push_back = accept;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          result.status = deq_pkg::ST_UNDER;
        end else begin
          ctrl.pop_front    = accept;
          result.read_value = cell_data[0];
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          result.status = deq_pkg::ST_UNDER;
        end else begin
          ctrl.pop_back     = accept;
          result.read_value = back_value;
        end
      end
      deq_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          result.status = deq_pkg::ST_UNDER;
        end else begin
          result.read_value = cell_data[0];
        end
      end
      deq_pkg::OP_PEEK_BACK: begin
        if (empty) begin
          result.status = deq_pkg::ST_UNDER;
        end else begin
          result.read_value = back_value;
        end
      end
      default: begin
        // Unused op codes give an ok status and change nothing.
      end
    endcase
  end

  // The row of cells. Cell 0 sees an occupied left neighbor carrying the
  // pushed word; the last cell sees a free right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             left_occ;
    logic signed [deq_pkg::DataW-1:0] left_data;
    logic                             right_occ;
    logic signed [deq_pkg::DataW-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_occ  = 1'b1;
      assign left_data = in_data.push_value;
    end else begin : g_inner_l
      assign left_occ  = occ_vec[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign right_occ  = 1'b0;
      assign right_data = '0;
    end else begin : g_inner_r
      assign right_occ  = occ_vec[i+1];
      assign right_data = cell_data[i+1];
    end

    assign last_vec[i] = occ_vec[i] && !right_occ;

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_occ   (left_occ),
      .left_data  (left_data),
      .right_occ  (right_occ),
      .right_data (right_data),
      .occ        (occ_vec[i]),
      .data       (cell_data[i])
    );
  end

  // At most one cell is flagged last, so the back word is a masked OR.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_data[i] & {deq_pkg::DataW{last_vec[i]}});
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The occupied cells must stay one unbroken run from cell 0.
  `DEQ_ASSERT_NEVER(a_occ_run, clk, rst_n, ((occ_vec + 1'b1) & occ_vec) != '0, "occupancy has a gap")

  // A push at the back that is not refused adds exactly one word.
  `DEQ_ASSERT(a_push_back_grows, clk, rst_n, accept && in_data.op == deq_pkg::OP_PUSH_BACK && !full |=> $countones(occ_vec) == $past($countones(occ_vec)) + 1, "push back did not add one word")

  // Any pop or peek on an empty deque must report underflow.
  `DEQ_ASSERT(a_underflow, clk, rst_n, accept && empty && (in_data.op == deq_pkg::OP_POP_FRONT || in_data.op == deq_pkg::OP_POP_BACK || in_data.op == deq_pkg::OP_PEEK_FRONT || in_data.op == deq_pkg::OP_PEEK_BACK) |=> out_valid && out_data.status == deq_pkg::ST_UNDER, "missing underflow")

endmodule

>>> src/deq_cell.sv
// One storage cell of the deque chain, holding a word and its occupancy.
`timescale 1ns / 1ps
module deq_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  deq_pkg::deq_ctrl_t               ctrl,
  input  logic                             left_occ,
  input  logic signed [deq_pkg::DataW-1:0] left_data,
  input  logic                             right_occ,
  input  logic signed [deq_pkg::DataW-1:0] right_data,
  output logic                             occ,
  output logic signed [deq_pkg::DataW-1:0] data
);

  logic                             occ_r;
  logic                             occ_nxt;
  logic signed [deq_pkg::DataW-1:0] data_r;
  logic signed [deq_pkg::DataW-1:0] data_nxt;

  // Front operations shift the whole chain; back operations touch only the
  // cell at the boundary between occupied and free cells.
  always_comb begin
    occ_nxt  = occ_r;
    data_nxt = data_r;
    if (ctrl.push_front) begin
      occ_nxt  = left_occ;
      data_nxt = left_data;
    end else if (ctrl.pop_front) begin
      occ_nxt  = right_occ;
      data_nxt = right_data;
    end else if (ctrl.push_back && !occ_r && left_occ) begin
      occ_nxt  = 1'b1;
      data_nxt = ctrl.push_value;
    end else if (ctrl.pop_back && occ_r && !right_occ) begin
      occ_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign occ  = occ_r;
  assign data = data_r;

endmodule
